// File: design/bts_pkg.sv
package bts_pkg;

    localparam int MAX_LOG2_SIDE = 8;
    localparam int WEIGHT_BITS   = 8;
    localparam int COORD_FRAC    = 16;
    localparam int ADDR_W        = 16;
    localparam int TEXEL_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int COORD_W       = 24;
    localparam int NUM_CHAN      = 3;
    localparam int NUM_TAPS      = 4;

    localparam int SIDE_LOG_W    = 4;
    localparam int POS_W         = MAX_LOG2_SIDE;
    localparam int WGT_W         = 2 * WEIGHT_BITS + 1;
    localparam int PROD_W        = CHAN_W + WGT_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int SHIFT_W       = COORD_W + MAX_LOG2_SIDE;

    localparam int PADDR_W       = 4;
    localparam int PDATA_W       = 32;

    localparam logic [PADDR_W-1:0] ADDR_LOG2_WIDTH    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_LOG2_HEIGHT   = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_TEXTURE_LOADED = 4'h8;

    localparam logic [SIDE_LOG_W-1:0] LOG2_SIDE_RESET = 4'd6;

    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

    typedef logic [WGT_W-1:0]  weight_t;
    typedef logic [PROD_W-1:0] prod_t;

    function automatic logic [SIDE_LOG_W-1:0] side_log(input logic [SIDE_LOG_W-1:0] lg);
        side_log = (lg > SIDE_LOG_W'(MAX_LOG2_SIDE)) ? SIDE_LOG_W'(MAX_LOG2_SIDE) : lg;
    endfunction

    function automatic logic [POS_W-1:0] side_mask(input logic [SIDE_LOG_W-1:0] lg);
        logic [POS_W:0] one_hot;
        one_hot   = (POS_W+1)'(1) << lg;
        side_mask = POS_W'(one_hot - (POS_W+1)'(1));
    endfunction

endpackage

// File: design/bilinear_texture_sampler_core.sv
// Channel | Dir | Ports                              | Item
// config  | in  | psel penable pwrite paddr pwdata   | register write/read (APB, pready high)
// input   | in  | s_tvalid s_tready s_tdata s_tuser  | texel write or sample request
// result  | out | m_tvalid m_tready m_tdata          | filtered ARGB, one per sample
//
// One item per cycle sustained, unless the pipeline is stalled. A sample result
// passes through four registers after acceptance: address, texel store read, weight
// products, sum/output. The texel store is kept in two copies, each read at
// two addresses per cycle. Writes give no result. Synchronous active-low reset
// clears control state and config; the store content is undefined until written.
// The whole pipeline stalls only while a result waits in the output register
// with m_tready low.
module bilinear_texture_sampler_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]      paddr,
    input  logic [bts_pkg::PDATA_W-1:0]      pwdata,
    output logic [bts_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // texel_address[15:0], texel_data[47:16], u_coord[71:48], v_coord[95:72]
    input  logic [95:0]                      s_tdata,
    // action[0]
    input  logic [0:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic [31:0]                      m_tdata
);

    localparam int AW = bts_pkg::ADDR_W;
    localparam int TW = bts_pkg::TEXEL_W;
    localparam int CW = bts_pkg::CHAN_W;
    localparam int PW = bts_pkg::POS_W;
    localparam int WB = bts_pkg::WEIGHT_BITS;
    localparam int LW = bts_pkg::SIDE_LOG_W;
    localparam int SW = bts_pkg::SHIFT_W;
    localparam int CF = bts_pkg::COORD_FRAC;
    localparam int CO = bts_pkg::COORD_W;
    localparam int NC = bts_pkg::NUM_CHAN;
    localparam int NT = bts_pkg::NUM_TAPS;

    // config registers
    logic [LW-1:0] log2_width_reg;
    logic [LW-1:0] log2_height_reg;
    logic          texture_loaded_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_width_reg     <= bts_pkg::LOG2_SIDE_RESET;
            log2_height_reg    <= bts_pkg::LOG2_SIDE_RESET;
            texture_loaded_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr)
                bts_pkg::ADDR_LOG2_WIDTH:     log2_width_reg     <= pwdata[LW-1:0];
                bts_pkg::ADDR_LOG2_HEIGHT:    log2_height_reg    <= pwdata[LW-1:0];
                bts_pkg::ADDR_TEXTURE_LOADED: texture_loaded_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            bts_pkg::ADDR_LOG2_WIDTH:     prdata = {{(32-LW){1'b0}}, log2_width_reg};
            bts_pkg::ADDR_LOG2_HEIGHT:    prdata = {{(32-LW){1'b0}}, log2_height_reg};
            bts_pkg::ADDR_TEXTURE_LOADED: prdata = {31'd0, texture_loaded_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // pipeline enable
    logic m_tvalid_reg;
    logic adv;
    logic in_acc;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign in_acc   = s_tvalid && adv;

    // stage 0: locate the four neighbours
    logic [AW-1:0] in_addr;
    logic [TW-1:0] in_texel;
    logic [CO-1:0] in_u;
    logic [CO-1:0] in_v;
    logic [LW-1:0] lw;
    logic [LW-1:0] lh;
    logic [PW-1:0] mask_w;
    logic [PW-1:0] mask_h;
    logic [SW-1:0] tu;
    logic [SW-1:0] tv;
    logic [PW-1:0] x0;
    logic [PW-1:0] x1;
    logic [PW-1:0] y0;
    logic [PW-1:0] y1;
    logic [AW-1:0] row0;
    logic [AW-1:0] row1;

    assign in_addr  = s_tdata[15:0];
    assign in_texel = s_tdata[16 +: TW];
    assign in_u     = s_tdata[48 +: CO];
    assign in_v     = s_tdata[72 +: CO];
    assign lw       = bts_pkg::side_log(log2_width_reg);
    assign lh       = bts_pkg::side_log(log2_height_reg);
    assign mask_w   = bts_pkg::side_mask(lw);
    assign mask_h   = bts_pkg::side_mask(lh);

    assign tu   = ({{(SW-CO){in_u[CO-1]}}, in_u} << lw) - (SW'(1) << (CF-1));
    assign tv   = ({{(SW-CO){in_v[CO-1]}}, in_v} << lh) - (SW'(1) << (CF-1));
    assign x0   = tu[CF +: PW] & mask_w;
    assign y0   = tv[CF +: PW] & mask_h;
    assign x1   = (x0 + PW'(1)) & mask_w;
    assign y1   = (y0 + PW'(1)) & mask_h;
    assign row0 = AW'({{(AW-PW){1'b0}}, y0} << lw);
    assign row1 = AW'({{(AW-PW){1'b0}}, y1} << lw);

    logic          p1_vld_reg;
    logic          p1_smp_reg;
    logic          p1_mag_reg;
    logic [AW-1:0] p1_waddr_reg;
    logic [TW-1:0] p1_wdata_reg;
    logic [AW-1:0] p1_ra00_reg;
    logic [AW-1:0] p1_ra10_reg;
    logic [AW-1:0] p1_ra01_reg;
    logic [AW-1:0] p1_ra11_reg;
    logic [WB-1:0] p1_fx_reg;
    logic [WB-1:0] p1_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (adv) begin
            p1_vld_reg <= in_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_smp_reg   <= (s_tuser[0] == bts_pkg::ACTION_SAMPLE);
            p1_mag_reg   <= !texture_loaded_reg;
            p1_waddr_reg <= in_addr;
            p1_wdata_reg <= in_texel;
            p1_ra00_reg  <= row0 | AW'(x0);
            p1_ra10_reg  <= row0 | AW'(x1);
            p1_ra01_reg  <= row1 | AW'(x0);
            p1_ra11_reg  <= row1 | AW'(x1);
            p1_fx_reg    <= tu[CF-1 -: WB];
            p1_fy_reg    <= tv[CF-1 -: WB];
        end
    end

    // stage 1: texel store access, weights
    logic [TW-1:0] store_a_reg [2**AW];
    logic [TW-1:0] store_b_reg [2**AW];
    logic [TW-1:0] c00_reg;
    logic [TW-1:0] c10_reg;
    logic [TW-1:0] c01_reg;
    logic [TW-1:0] c11_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (p1_vld_reg && !p1_smp_reg) begin
                store_a_reg[p1_waddr_reg] <= p1_wdata_reg;
            end
            c00_reg <= store_a_reg[p1_ra00_reg];
            c10_reg <= store_a_reg[p1_ra10_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (p1_vld_reg && !p1_smp_reg) begin
                store_b_reg[p1_waddr_reg] <= p1_wdata_reg;
            end
            c01_reg <= store_b_reg[p1_ra01_reg];
            c11_reg <= store_b_reg[p1_ra11_reg];
        end
    end

    logic [WB:0] sx;
    logic [WB:0] sy;
    logic [WB:0] ex;
    logic [WB:0] ey;

    assign ex = {1'b0, p1_fx_reg};
    assign ey = {1'b0, p1_fy_reg};
    assign sx = ((WB+1)'(1) << WB) - ex;
    assign sy = ((WB+1)'(1) << WB) - ey;

    logic              p2_vld_reg;
    logic              p2_mag_reg;
    bts_pkg::weight_t  p2_w_reg [NT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (adv) begin
            p2_vld_reg <= p1_vld_reg && p1_smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_mag_reg  <= p1_mag_reg;
            p2_w_reg[0] <= bts_pkg::WGT_W'(sx * sy);
            p2_w_reg[1] <= bts_pkg::WGT_W'(ex * sy);
            p2_w_reg[2] <= bts_pkg::WGT_W'(sx * ey);
            p2_w_reg[3] <= bts_pkg::WGT_W'(ex * ey);
        end
    end

    // stage 2: channel products
    logic [TW-1:0] tap [NT];

    assign tap[0] = c00_reg;
    assign tap[1] = c10_reg;
    assign tap[2] = c01_reg;
    assign tap[3] = c11_reg;

    logic            p3_vld_reg;
    logic            p3_mag_reg;
    bts_pkg::prod_t  p3_prod_reg [NC][NT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (adv) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_mag_reg <= p2_mag_reg;
            for (int c = 0; c < NC; c++) begin
                for (int k = 0; k < NT; k++) begin
                    p3_prod_reg[c][k] <= bts_pkg::PROD_W'(
                        tap[k][(NC-1-c)*CW +: CW] * p2_w_reg[k]);
                end
            end
        end
    end

    // stage 3: sum and output register
    logic [bts_pkg::SUM_W-1:0] sum [NC];
    logic [CW-1:0]             chan [NC];

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            sum[c] = bts_pkg::SUM_W'(p3_prod_reg[c][0]) + bts_pkg::SUM_W'(p3_prod_reg[c][1])
                   + bts_pkg::SUM_W'(p3_prod_reg[c][2]) + bts_pkg::SUM_W'(p3_prod_reg[c][3]);
            chan[c] = sum[c][2*WB +: CW];
        end
    end

    logic [31:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (p3_mag_reg) begin
                m_tdata_reg <= {bts_pkg::CHAN_FULL, bts_pkg::CHAN_FULL,
                                bts_pkg::CHAN_ZERO, bts_pkg::CHAN_FULL};
            end else begin
                m_tdata_reg <= {bts_pkg::CHAN_FULL, chan[2], chan[1], chan[0]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/sv/tb_bilinear_texture_sampler_core.sv
module tb_bilinear_texture_sampler_core;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int LOADED_LOG2  = 8;   // texels 0..255 are written before any sample with the texture marked loaded

    localparam logic [5:0][bts_pkg::COORD_W-1:0] EDGE_U = {
        24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h008000, 24'h010000
    };
    localparam logic [5:0][bts_pkg::COORD_W-1:0] EDGE_V = {
        24'h000000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h008000, 24'h00FF00
    };

    typedef struct packed {
        logic [bts_pkg::CHAN_W-1:0] alpha;
        logic [bts_pkg::CHAN_W-1:0] blue;
        logic [bts_pkg::CHAN_W-1:0] green;
        logic [bts_pkg::CHAN_W-1:0] red;
    } argb_t;

    logic                        aclk    = 1'b0;
    logic                        aresetn = 1'b0;

    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [bts_pkg::PADDR_W-1:0] paddr   = '0;
    logic [bts_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [bts_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // texel_address[15:0], texel_data[47:16], u_coord[71:48], v_coord[95:72]
    logic [95:0]        s_tdata  = '0;
    // action[0]
    logic [0:0]         s_tuser  = '0;

    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic [31:0]        m_tdata;

    // shadow of the block's state
    logic [bts_pkg::TEXEL_W-1:0]    texel_mirror [0:(1<<bts_pkg::ADDR_W)-1];
    logic [bts_pkg::SIDE_LOG_W-1:0] lw_reg;
    logic [bts_pkg::SIDE_LOG_W-1:0] lh_reg;
    logic                           loaded_reg;
    argb_t                          pending_colors [$];

    string channel_name [4] = '{"red", "green", "blue", "alpha"};

    int  error_count   = 0;
    int  writes_sent   = 0;
    int  samples_sent  = 0;
    int  results_seen  = 0;
    int  config_count  = 0;
    int  idle_count    = 0;
    int  hold_request  = 0;
    bit  steady_mode   = 1'b0;

    bilinear_texture_sampler_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [bts_pkg::COORD_W-1:0] random_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return bts_pkg::COORD_W'($urandom);
        if (r < 85) return bts_pkg::COORD_W'($urandom_range(0, 'h1FFFF));
        return bts_pkg::COORD_W'(0 - int'($urandom_range(1, 'h1FFFF)));
    endfunction

    // coord * 2^lg - 1/2, split into wrapped texel position and blend weight
    function automatic void split_coord(input logic [bts_pkg::COORD_W-1:0] c, input int lg,
                                        output int pos, output int wgt);
        logic [63:0] t;
        t   = ({{(64-bts_pkg::COORD_W){c[bts_pkg::COORD_W-1]}}, c} << lg)
            - (64'd1 << (bts_pkg::COORD_FRAC - 1));
        wgt = int'(t[bts_pkg::COORD_FRAC-1:0] >> (bts_pkg::COORD_FRAC - bts_pkg::WEIGHT_BITS));
        pos = int'(t[bts_pkg::COORD_FRAC+31:bts_pkg::COORD_FRAC]) & ((1 << lg) - 1);
    endfunction

    function automatic logic [bts_pkg::TEXEL_W-1:0] texel_at(input int x, input int y,
                                                             input int lw);
        return texel_mirror[bts_pkg::ADDR_W'((y << lw) | x)];
    endfunction

    function automatic logic [bts_pkg::CHAN_W-1:0] mix_channel(
        input logic [bts_pkg::CHAN_W-1:0] c00, c10, c01, c11, input int fx, fy);
        longint unsigned s, sum;
        s   = longint'(1) << bts_pkg::WEIGHT_BITS;
        sum = c00 * (s - fx) * (s - fy) + c10 * fx * (s - fy)
            + c01 * (s - fx) * fy + c11 * fx * fy;
        return sum[2*bts_pkg::WEIGHT_BITS +: bts_pkg::CHAN_W];
    endfunction

    function automatic argb_t filtered_color(input logic [bts_pkg::COORD_W-1:0] u, v);
        argb_t c;
        int lw, lh, x0, y0, x1, y1, fx, fy;
        logic [bts_pkg::TEXEL_W-1:0] t00, t10, t01, t11;
        c.alpha = bts_pkg::CHAN_FULL;
        if (!loaded_reg) begin
            c.red   = bts_pkg::CHAN_FULL;
            c.green = bts_pkg::CHAN_ZERO;
            c.blue  = bts_pkg::CHAN_FULL;
            return c;
        end
        lw = (lw_reg > bts_pkg::MAX_LOG2_SIDE) ? bts_pkg::MAX_LOG2_SIDE : int'(lw_reg);
        lh = (lh_reg > bts_pkg::MAX_LOG2_SIDE) ? bts_pkg::MAX_LOG2_SIDE : int'(lh_reg);
        split_coord(u, lw, x0, fx);
        split_coord(v, lh, y0, fy);
        x1 = (x0 + 1) & ((1 << lw) - 1);
        y1 = (y0 + 1) & ((1 << lh) - 1);
        t00 = texel_at(x0, y0, lw);
        t10 = texel_at(x1, y0, lw);
        t01 = texel_at(x0, y1, lw);
        t11 = texel_at(x1, y1, lw);
        c.red   = mix_channel(t00[23:16], t10[23:16], t01[23:16], t11[23:16], fx, fy);
        c.green = mix_channel(t00[15:8], t10[15:8], t01[15:8], t11[15:8], fx, fy);
        c.blue  = mix_channel(t00[7:0], t10[7:0], t01[7:0], t11[7:0], fx, fy);
        return c;
    endfunction

    function automatic logic [bts_pkg::PDATA_W-1:0] reg_shadow(
        input logic [bts_pkg::PADDR_W-1:0] addr);
        case (addr)
            bts_pkg::ADDR_LOG2_WIDTH:  return bts_pkg::PDATA_W'(lw_reg);
            bts_pkg::ADDR_LOG2_HEIGHT: return bts_pkg::PDATA_W'(lh_reg);
            default:                   return bts_pkg::PDATA_W'(loaded_reg);
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic [bts_pkg::PADDR_W-1:0] addr,
                              input logic [bts_pkg::PDATA_W-1:0] wdata,
                              output logic [bts_pkg::PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [bts_pkg::PADDR_W-1:0] addr);
        logic [bts_pkg::PDATA_W-1:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== reg_shadow(addr)) begin
            $display("%0t: register %h read back, expected %h, got %h",
                     $time, addr, reg_shadow(addr), rd);
            error_count++;
        end
    endtask

    task automatic write_reg(input logic [bts_pkg::PADDR_W-1:0] addr,
                             input logic [bts_pkg::SIDE_LOG_W-1:0] value);
        logic [bts_pkg::PDATA_W-1:0] rd;
        apb_access(1'b1, addr, bts_pkg::PDATA_W'(value), rd);
        case (addr)
            bts_pkg::ADDR_LOG2_WIDTH:     lw_reg = value;
            bts_pkg::ADDR_LOG2_HEIGHT:    lh_reg = value;
            bts_pkg::ADDR_TEXTURE_LOADED: loaded_reg = value[0];
            default: ;
        endcase
        check_reg(addr);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input int lw, input int lh, input bit loaded);
        quiesce();
        write_reg(bts_pkg::ADDR_LOG2_WIDTH, bts_pkg::SIDE_LOG_W'(lw));
        write_reg(bts_pkg::ADDR_LOG2_HEIGHT, bts_pkg::SIDE_LOG_W'(lh));
        write_reg(bts_pkg::ADDR_TEXTURE_LOADED, bts_pkg::SIDE_LOG_W'(loaded));
        config_count++;
    endtask

    task automatic send_item(input logic act, input logic [bts_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data,
                             input logic [bts_pkg::COORD_W-1:0] u, v);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {v, u, data, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (act == bts_pkg::ACTION_WRITE) begin
            texel_mirror[addr] = data[bts_pkg::TEXEL_W-1:0];
            writes_sent++;
        end else begin
            pending_colors.push_back(filtered_color(u, v));
            samples_sent++;
        end
    endtask

    task automatic random_item(input int sample_pct);
        logic [bts_pkg::ADDR_W-1:0] addr;
        logic                       act;
        addr = ($urandom_range(0, 3) == 0) ? bts_pkg::ADDR_W'($urandom_range(0, 255))
                                           : bts_pkg::ADDR_W'($urandom);
        act  = ($urandom_range(0, 99) < sample_pct) ? bts_pkg::ACTION_SAMPLE
                                                    : bts_pkg::ACTION_WRITE;
        send_item(act, addr, $urandom, random_coord(), random_coord());
    endtask

    task automatic test_register_reset();
        check_reg(bts_pkg::ADDR_LOG2_WIDTH);
        check_reg(bts_pkg::ADDR_LOG2_HEIGHT);
        check_reg(bts_pkg::ADDR_TEXTURE_LOADED);
    endtask

    task automatic test_unloaded_magenta();
        send_item(bts_pkg::ACTION_SAMPLE, 16'h0000, 32'h0, EDGE_U[0], EDGE_V[0]);
        send_item(bts_pkg::ACTION_WRITE, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(bts_pkg::ACTION_SAMPLE, 16'hFFFF, 32'hFFFFFFFF, EDGE_U[1], EDGE_V[1]);
        send_item(bts_pkg::ACTION_WRITE, 16'h8000, 32'h80808080, 24'h0, 24'h0);
        send_item(bts_pkg::ACTION_SAMPLE, 16'h0000, 32'h0, EDGE_U[2], EDGE_V[2]);
    endtask

    task automatic test_texture_load();
        logic [31:0] data;
        for (int a = 0; a < (1 << LOADED_LOG2); a++) begin
            case (a % 17)
                0:       data = 32'hFFFFFFFF;
                1:       data = 32'h00000000;
                default: data = $urandom;
            endcase
            send_item(bts_pkg::ACTION_WRITE, bts_pkg::ADDR_W'(a), data,
                      random_coord(), random_coord());
        end
    endtask

    task automatic test_directed_filtering();
        set_config(15, 0, 1'b1);
        for (int k = 0; k < 6; k++)
            send_item(bts_pkg::ACTION_SAMPLE, 16'h0, 32'h0, EDGE_U[k], EDGE_V[k]);
        set_config(0, 15, 1'b1);
        for (int k = 0; k < 6; k++)
            send_item(bts_pkg::ACTION_SAMPLE, 16'h0, 32'h0, EDGE_U[k], EDGE_V[k]);
        set_config(0, 0, 1'b1);
        for (int k = 0; k < 6; k++)
            send_item(bts_pkg::ACTION_SAMPLE, 16'h0, 32'h0, EDGE_U[k], EDGE_V[k]);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int lw, lh;
        for (int p = 0; p < phases; p++) begin
            lw = $urandom_range(0, 15);
            lh = $urandom_range(0, LOADED_LOG2 -
                 ((lw > bts_pkg::MAX_LOG2_SIDE) ? bts_pkg::MAX_LOG2_SIDE : lw));
            if (lw == 0 && $urandom_range(0, 1) == 1)
                lh = $urandom_range(bts_pkg::MAX_LOG2_SIDE, 15);
            steady_mode = ($urandom_range(0, 4) == 0);
            set_config(lw, lh, $urandom_range(0, 5) != 0);
            repeat (per_phase) random_item(70);
        end
        steady_mode = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_config(3, 4, 1'b1);
        steady_mode  = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (60) random_item(100);
        steady_mode  = 1'b0;
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && $urandom_range(0, 99) < 25) begin
                stall_left = idle_gap();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        argb_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_colors.pop_front();
                results_seen++;
                for (int k = 0; k < 4; k++) begin
                    if (got[8*k +: 8] !== want[8*k +: 8]) begin
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                 channel_name[k], want[8*k +: 8], got[8*k +: 8]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("%0t: timeout, %0d results still pending", $time, pending_colors.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : main_sequence
        lw_reg     = bts_pkg::LOG2_SIDE_RESET;
        lh_reg     = bts_pkg::LOG2_SIDE_RESET;
        loaded_reg = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_unloaded_magenta();
        test_texture_load();
        test_directed_filtering();
        test_random_phases(10, 65);
        test_output_backpressure();
        quiesce();
        $display("run covered %0d texel writes and %0d samples, %0d results checked",
                 writes_sent, samples_sent, results_seen);
        $display("%0d register settings incl. clamped sides, 1x1 texture and unloaded store",
                 config_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: bilinear_texture_sampler_core.f
design/bts_pkg.sv
design/bilinear_texture_sampler_core.sv
tb/sv/tb_bilinear_texture_sampler_core.sv
